>>> sv/assert_macros.svh
// Assertion macros used by the deque top RTL file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

>>> sv/dqvdm_pkg.sv
// Shared types and command codes for the deque cell chain.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dqvdm_pkg;

   // commands broadcast to every cell
   localparam logic [2:0] CMD_HOLD       = 3'd0;
   localparam logic [2:0] CMD_PUSH_FRONT = 3'd1;
   localparam logic [2:0] CMD_PUSH_BACK  = 3'd2;
   localparam logic [2:0] CMD_MARK       = 3'd3;
   localparam logic [2:0] CMD_SWAP       = 3'd4;
   localparam logic [2:0] CMD_TRIM       = 3'd5;
   localparam logic [2:0] CMD_CLEAR      = 3'd6;

   typedef struct packed {
      logic [2:0] cmd;
      logic       phase;   // odd-even pairing select during compaction
   } cell_ctl_type;

   typedef struct packed {
      logic occ;    // holds an entry
      logic dead;   // entry marked for delete
   } cell_flags_type;

endpackage

`default_nettype wire

>>> sv/dqvdm_cell.sv
// One deque cell: an entry, its occupancy/delete flags and a running
// max/count stage. Depends on dqvdm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dqvdm_cell #(
   parameter int         VALUE_WIDTH = 32,
   parameter int         CNT_WIDTH   = 5,
   parameter logic       PARITY      = 1'b0
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire dqvdm_pkg::cell_ctl_type    ctl,
   input  wire [VALUE_WIDTH-1:0]           item_val,
   input  wire [VALUE_WIDTH-1:0]           left_val,
   input  wire dqvdm_pkg::cell_flags_type  left_flags,
   input  wire [VALUE_WIDTH-1:0]           left_max,
   input  wire [CNT_WIDTH-1:0]             left_cnt,
   input  wire [VALUE_WIDTH-1:0]           right_val,
   input  wire dqvdm_pkg::cell_flags_type  right_flags,
   output logic [VALUE_WIDTH-1:0]          val,
   output dqvdm_pkg::cell_flags_type       flags,
   output logic [VALUE_WIDTH-1:0]          run_max,
   output logic [CNT_WIDTH-1:0]            run_cnt
);

   localparam logic [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

   logic [VALUE_WIDTH-1:0] val_ff, val_in;
   logic                   occ_ff, occ_in;
   logic                   dead_ff, dead_in;
   logic [VALUE_WIDTH-1:0] max_ff, max_in;
   logic [CNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic                   live;

   always_comb begin
      val_in  = val_ff;
      occ_in  = occ_ff;
      dead_in = dead_ff;
      unique case (ctl.cmd)
         dqvdm_pkg::CMD_PUSH_FRONT: begin
            val_in = left_val;
            occ_in = left_flags.occ;
         end
         dqvdm_pkg::CMD_PUSH_BACK: begin
            if (!occ_ff && left_flags.occ) begin
               val_in = item_val;
               occ_in = 1'b1;
            end
         end
         dqvdm_pkg::CMD_MARK: begin
            dead_in = occ_ff && (val_ff == item_val);
         end
         dqvdm_pkg::CMD_SWAP: begin
            // left of pair: pull a live right neighbor into a dead slot
            if (ctl.phase == PARITY) begin
               if (occ_ff && dead_ff && right_flags.occ && !right_flags.dead) begin
                  val_in  = right_val;
                  dead_in = 1'b0;
               end
            end else if (left_flags.occ && left_flags.dead && occ_ff && !dead_ff) begin
               dead_in = 1'b1;
            end
         end
         dqvdm_pkg::CMD_TRIM: begin
            occ_in  = occ_ff && !dead_ff;
            dead_in = 1'b0;
         end
         dqvdm_pkg::CMD_CLEAR: begin
            occ_in  = 1'b0;
            dead_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   assign live   = occ_ff && !dead_ff;
   assign max_in = (live && ($signed(val_ff) > $signed(left_max))) ? val_ff : left_max;
   assign cnt_in = left_cnt + CNT_WIDTH'(live);

   always_ff @(posedge clock) begin
      val_ff <= val_in;
      if (reset) begin
         occ_ff  <= 1'b0;
         dead_ff <= 1'b0;
         max_ff  <= VAL_MIN;
         cnt_ff  <= '0;
      end else begin
         occ_ff  <= occ_in;
         dead_ff <= dead_in;
         max_ff  <= max_in;
         cnt_ff  <= cnt_in;
      end
   end

   assign val        = val_ff;
   assign flags.occ  = occ_ff;
   assign flags.dead = dead_ff;
   assign run_max    = max_ff;
   assign run_cnt    = cnt_ff;

endmodule

`default_nettype wire

>>> sv/deque_with_value_delete_and_max_top.sv
// A read, an unused mode or a push to a full queue goes from S_APPLY straight to S_DONE;
// a push or clear first waits in S_SETTLE while the max/count wave crosses the chain; a
// delete runs a mark, DEPTH odd-even compaction rounds, a trim, then the wave. One word in
// flight: the next word is taken in the cycle after the result loads. Reset (synchronous,
// active high) empties the queue and clears rsp_valid. Uses dqvdm_pkg, dqvdm_cell.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module deque_with_value_delete_and_max_top #(
   parameter int DEPTH       = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   input  wire [2:0]         req_mode,
   input  wire signed [31:0] req_value,
   input  wire [3:0]         req_position,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output logic signed [31:0] rsp_read_value,
   output logic signed [31:0] rsp_max_value,
   output logic [4:0]        rsp_entry_count,
   output logic              rsp_is_empty,
   output logic              rsp_is_full,
   output logic              rsp_found
);

   localparam int CNT_WIDTH = $clog2(DEPTH + 1);
   localparam int CNT_EXT   = (CNT_WIDTH > 5) ? CNT_WIDTH : 5;
   localparam int VAL_EXT   = (VALUE_WIDTH > 32) ? VALUE_WIDTH : 32;
   localparam int RD_SPAN   = (DEPTH < 16) ? DEPTH : 16;
   localparam logic [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

   localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
   localparam logic [2:0] MODE_PUSH_BACK  = 3'd1;
   localparam logic [2:0] MODE_DELETE     = 3'd2;
   localparam logic [2:0] MODE_CLEAR      = 3'd3;
   localparam logic [2:0] MODE_READ       = 3'd4;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_APPLY  = 3'd1;
   localparam logic [2:0] S_SORT   = 3'd2;
   localparam logic [2:0] S_TRIM   = 3'd3;
   localparam logic [2:0] S_SETTLE = 3'd4;
   localparam logic [2:0] S_DONE   = 3'd5;

   // sequencer and captured word
   logic [2:0]            state_ff, state_in;
   logic [CNT_WIDTH-1:0]  step_ff, step_in;
   logic [2:0]            mode_ff;
   logic signed [31:0]    value_ff;
   logic [3:0]            pos_ff;
   logic [CNT_WIDTH-1:0]  old_cnt_ff, old_cnt_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]    rsp_read_value_ff, rsp_read_value_in;
   logic signed [31:0]    rsp_max_value_ff, rsp_max_value_in;
   logic [4:0]            rsp_entry_count_ff, rsp_entry_count_in;
   logic                  rsp_is_empty_ff, rsp_is_empty_in;
   logic                  rsp_is_full_ff, rsp_is_full_in;
   logic                  rsp_found_ff, rsp_found_in;

   // chain wiring
   dqvdm_pkg::cell_ctl_type   ctl;
   logic [VALUE_WIDTH-1:0]    item_val;
   logic [VAL_EXT-1:0]        item_ext;
   logic [VALUE_WIDTH-1:0]    cell_val   [DEPTH];
   dqvdm_pkg::cell_flags_type cell_flags [DEPTH];
   logic [VALUE_WIDTH-1:0]    cell_max   [DEPTH];
   logic [CNT_WIDTH-1:0]      cell_cnt   [DEPTH];
   logic [VALUE_WIDTH-1:0]    lv         [DEPTH];
   dqvdm_pkg::cell_flags_type lf         [DEPTH];
   logic [VALUE_WIDTH-1:0]    lm         [DEPTH];
   logic [CNT_WIDTH-1:0]      lc         [DEPTH];
   logic [VALUE_WIDTH-1:0]    rv         [DEPTH];
   dqvdm_pkg::cell_flags_type rf         [DEPTH];
   logic [DEPTH-1:0]          occ_vec;
   logic [DEPTH-1:0]          dead_vec;
   logic [DEPTH-1:0]          occ_gap;

   logic                   full;
   logic                   step_last;
   logic                   accept;
   logic                   rsp_load;
   logic                   at_rest;
   logic [CNT_WIDTH-1:0]   cnt_last;
   logic [CNT_EXT-1:0]     cnt_ext;
   logic                   rd_hit;
   logic [VALUE_WIDTH-1:0] rd_val;
   logic [VAL_EXT-1:0]     rd_ext;
   logic [VAL_EXT-1:0]     max_ext;

   assign item_ext = VAL_EXT'(value_ff);
   assign item_val = item_ext[VALUE_WIDTH-1:0];

   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_cell
         if (g == 0) begin : g_head
            assign lv[g] = item_val;
            assign lf[g] = '{occ: 1'b1, dead: 1'b0};
            assign lm[g] = VAL_MIN;
            assign lc[g] = '0;
         end else begin : g_link
            assign lv[g] = cell_val[g-1];
            assign lf[g] = cell_flags[g-1];
            assign lm[g] = cell_max[g-1];
            assign lc[g] = cell_cnt[g-1];
         end
         if (g == DEPTH - 1) begin : g_tail
            assign rv[g] = item_val;
            assign rf[g] = '{occ: 1'b0, dead: 1'b0};
         end else begin : g_next
            assign rv[g] = cell_val[g+1];
            assign rf[g] = cell_flags[g+1];
         end

         dqvdm_cell #(
            .VALUE_WIDTH (VALUE_WIDTH),
            .CNT_WIDTH   (CNT_WIDTH),
            .PARITY      (1'(g % 2))
         ) u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctl         (ctl),
            .item_val    (item_val),
            .left_val    (lv[g]),
            .left_flags  (lf[g]),
            .left_max    (lm[g]),
            .left_cnt    (lc[g]),
            .right_val   (rv[g]),
            .right_flags (rf[g]),
            .val         (cell_val[g]),
            .flags       (cell_flags[g]),
            .run_max     (cell_max[g]),
            .run_cnt     (cell_cnt[g])
         );

         assign occ_vec[g]  = cell_flags[g].occ;
         assign dead_vec[g] = cell_flags[g].dead;
      end
   endgenerate

   assign occ_gap   = occ_vec & ~{occ_vec[DEPTH-2:0], 1'b1};
   assign full      = occ_vec[DEPTH-1];
   assign cnt_last  = cell_cnt[DEPTH-1];
   assign cnt_ext   = CNT_EXT'(cnt_last);
   assign step_last = (step_ff == CNT_WIDTH'(DEPTH - 1));
   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_load  = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);
   assign at_rest   = (state_ff == S_IDLE) || (state_ff == S_DONE);

   // sequencer
   always_comb begin
      state_in   = state_ff;
      step_in    = '0;
      old_cnt_in = old_cnt_ff;
      ctl.cmd    = dqvdm_pkg::CMD_HOLD;
      ctl.phase  = step_ff[0];
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            old_cnt_in = cnt_last;
            state_in   = S_DONE;
            unique case (mode_ff)
               MODE_PUSH_FRONT: begin
                  if (!full) begin
                     ctl.cmd  = dqvdm_pkg::CMD_PUSH_FRONT;
                     state_in = S_SETTLE;
                  end
               end
               MODE_PUSH_BACK: begin
                  if (!full) begin
                     ctl.cmd  = dqvdm_pkg::CMD_PUSH_BACK;
                     state_in = S_SETTLE;
                  end
               end
               MODE_DELETE: begin
                  ctl.cmd  = dqvdm_pkg::CMD_MARK;
                  state_in = S_SORT;
               end
               MODE_CLEAR: begin
                  ctl.cmd  = dqvdm_pkg::CMD_CLEAR;
                  state_in = S_SETTLE;
               end
               default: begin
               end
            endcase
         end
         S_SORT: begin
            ctl.cmd = dqvdm_pkg::CMD_SWAP;
            if (step_last) begin
               state_in = S_TRIM;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_TRIM: begin
            ctl.cmd  = dqvdm_pkg::CMD_TRIM;
            state_in = S_SETTLE;
         end
         S_SETTLE: begin
            // wait for the max/count wave to reach the last cell
            if (step_last) begin
               state_in = S_DONE;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // read select over the cells a 4-bit position can reach
   always_comb begin
      rd_hit = 1'b0;
      rd_val = '0;
      for (int i = 0; i < RD_SPAN; i++) begin
         if (pos_ff == 4'(i)) begin
            rd_hit = occ_vec[i];
            rd_val = cell_val[i];
         end
      end
   end

   assign rd_ext  = VAL_EXT'($signed(rd_val));
   assign max_ext = VAL_EXT'($signed(cell_max[DEPTH-1]));

   always_comb begin
      rsp_valid_in       = rsp_valid_ff && !rsp_ready;
      rsp_read_value_in  = rsp_read_value_ff;
      rsp_max_value_in   = rsp_max_value_ff;
      rsp_entry_count_in = rsp_entry_count_ff;
      rsp_is_empty_in    = rsp_is_empty_ff;
      rsp_is_full_in     = rsp_is_full_ff;
      rsp_found_in       = rsp_found_ff;
      if (rsp_load) begin
         rsp_valid_in       = 1'b1;
         rsp_read_value_in  = ((mode_ff == MODE_READ) && rd_hit) ? rd_ext[31:0] : '0;
         rsp_max_value_in   = max_ext[31:0];
         rsp_entry_count_in = cnt_ext[4:0];
         rsp_is_empty_in    = (cnt_last == '0);
         rsp_is_full_in     = (cnt_last == CNT_WIDTH'(DEPTH));
         priority if (mode_ff == MODE_DELETE) begin
            rsp_found_in = (cnt_last != old_cnt_ff);
         end else if (mode_ff == MODE_READ) begin
            rsp_found_in = rd_hit;
         end else begin
            rsp_found_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff  <= req_mode;
         value_ff <= req_value;
         pos_ff   <= req_position;
      end
      old_cnt_ff         <= old_cnt_in;
      rsp_read_value_ff  <= rsp_read_value_in;
      rsp_max_value_ff   <= rsp_max_value_in;
      rsp_entry_count_ff <= rsp_entry_count_in;
      rsp_is_empty_ff    <= rsp_is_empty_in;
      rsp_is_full_ff     <= rsp_is_full_in;
      rsp_found_ff       <= rsp_found_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_value  = rsp_read_value_ff;
   assign rsp_max_value   = rsp_max_value_ff;
   assign rsp_entry_count = rsp_entry_count_ff;
   assign rsp_is_empty    = rsp_is_empty_ff;
   assign rsp_is_full     = rsp_is_full_ff;
   assign rsp_found       = rsp_found_ff;

   // occupied cells always form a run from the front
   `ASSERT_IMPLIES(a_occ_contiguous, clock, reset, 1'b1, occ_gap == '0)
   // delete marks exist only while a delete is being compacted
   `ASSERT_IMPLIES(a_no_dead_outside_delete, clock, reset, at_rest, dead_vec == '0)
   // count wave has settled by the time a word is reported
   `ASSERT_IMPLIES(a_count_settled, clock, reset, state_ff == S_DONE, $countones(occ_vec) == int'(cnt_last))
   // a loaded result shows up and frees the input side
   `ASSERT_NEXT(a_done_loads_rsp, clock, reset, rsp_load, rsp_valid_ff && state_ff == S_IDLE)

endmodule

`default_nettype wire

>>> dv/deque_checker.sv
// Op codes shared by the testbench, plus the response checker for the deque top:
// a behavioral deque predicts every response and the DUT output is compared in order.
// Depends only on the DUT port list; compile ahead of tb_top.
`timescale 1ns / 1ps

package deque_op_pkg;
   typedef enum logic [2:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_DELETE     = 3'd2,
      OP_CLEAR      = 3'd3,
      OP_READ       = 3'd4,
      OP_UNUSED5    = 3'd5,
      OP_UNUSED6    = 3'd6,
      OP_UNUSED7    = 3'd7
   } deque_op_type;
endpackage

module deque_checker #(
   parameter int DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [2:0]  req_mode,
   input  logic [31:0] req_value,
   input  logic [3:0]  req_position,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_read_value,
   input  logic [31:0] rsp_max_value,
   input  logic [4:0]  rsp_entry_count,
   input  logic        rsp_is_empty,
   input  logic        rsp_is_full,
   input  logic        rsp_found,
   output int          fail_count,
   output int          pending,
   output int          checked,
   output int          drops,
   output int          delete_hits
);

   localparam logic [31:0] MOST_NEGATIVE = 32'h8000_0000;

   typedef struct packed {
      logic [31:0] read_value;
      logic [31:0] max_value;
      logic [4:0]  entry_count;
      logic        is_empty;
      logic        is_full;
      logic        found;
   } deque_status_type;

   logic signed [31:0]          slots [DEPTH];
   int                          fill;
   deque_status_type            status_due [$];
   deque_status_type            due;
   deque_status_type            next_status;
   deque_op_pkg::deque_op_type  op;

   // Applies one word to the model deque and returns the status it should report.
   function automatic deque_status_type apply_word(
      input deque_op_pkg::deque_op_type op_in,
      input logic signed [31:0]         val,
      input logic [3:0]                 pos);
      deque_status_type   s;
      int                 keep;
      logic signed [31:0] best;
      s = '0;
      case (op_in)
         deque_op_pkg::OP_PUSH_FRONT: begin
            if (fill < DEPTH) begin
               for (int i = fill; i > 0; i--) slots[i] = slots[i - 1];
               slots[0] = val;
               fill++;
            end
         end
         deque_op_pkg::OP_PUSH_BACK: begin
            if (fill < DEPTH) begin
               slots[fill] = val;
               fill++;
            end
         end
         deque_op_pkg::OP_DELETE: begin
            // compact survivors toward the front, order kept
            keep = 0;
            for (int i = 0; i < fill; i++) begin
               if (slots[i] == val) s.found = 1'b1;
               else begin
                  slots[keep] = slots[i];
                  keep++;
               end
            end
            fill = keep;
         end
         deque_op_pkg::OP_CLEAR: fill = 0;
         deque_op_pkg::OP_READ: begin
            if (pos < fill) begin
               s.read_value = slots[pos];
               s.found      = 1'b1;
            end
         end
         default: ;
      endcase
      best = MOST_NEGATIVE;
      for (int i = 0; i < fill; i++) if (slots[i] > best) best = slots[i];
      s.max_value   = best;
      s.entry_count = 5'(fill);
      s.is_empty    = (fill == 0);
      s.is_full     = (fill == DEPTH);
      return s;
   endfunction

   task automatic check_field(input string label, input logic [31:0] want,
                              input logic [31:0] seen);
      if (want !== seen) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, label, want, seen);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         fill = 0;
         status_due.delete();
         pending <= 0;
      end else begin
         // retire the response first: it always belongs to an older word
         if (rsp_valid && rsp_ready) begin
            if (status_due.size() == 0) begin
               $display("%0t: response with nothing outstanding, count %0d", $time,
                        rsp_entry_count);
               fail_count++;
            end else begin
               due = status_due.pop_front();
               check_field("read_value",  due.read_value,  rsp_read_value);
               check_field("max_value",   due.max_value,   rsp_max_value);
               check_field("entry_count", due.entry_count, rsp_entry_count);
               check_field("is_empty",    due.is_empty,    rsp_is_empty);
               check_field("is_full",     due.is_full,     rsp_is_full);
               check_field("found",       due.found,       rsp_found);
               checked++;
            end
         end
         if (req_valid && req_ready) begin
            op = deque_op_pkg::deque_op_type'(req_mode);
            if ((op == deque_op_pkg::OP_PUSH_FRONT || op == deque_op_pkg::OP_PUSH_BACK)
                && fill == DEPTH) drops++;
            next_status = apply_word(op, req_value, req_position);
            if (op == deque_op_pkg::OP_DELETE && next_status.found) delete_hits++;
            status_due.push_back(next_status);
         end
         pending <= status_due.size();
      end
   end

endmodule

>>> dv/tb_top.sv
// Top of the deque testbench: clock, reset, word stimulus, response back-pressure,
// watchdog and verdict. Depends on deque_checker.sv (op package, checker) and the DUT.
`timescale 1ns / 1ps

module tb_top;

   localparam int STALL_LIMIT  = 2000;
   localparam int HOLD_CYCLES  = 400;
   localparam int RANDOM_WORDS = 1425;

   logic        clock        = 1'b0;
   logic        reset        = 1'b1;
   logic        req_valid    = 1'b0;
   logic [2:0]  req_mode     = '0;
   logic [31:0] req_value    = '0;
   logic [3:0]  req_position = '0;
   logic        rsp_ready    = 1'b0;

   logic               req_ready;
   logic               rsp_valid;
   logic signed [31:0] rsp_read_value;
   logic signed [31:0] rsp_max_value;
   logic [4:0]         rsp_entry_count;
   logic               rsp_is_empty;
   logic               rsp_is_full;
   logic               rsp_found;

   int fail_count, pending, checked, drops, delete_hits;
   int words_sent   = 0;
   int stall_cycles = 0;
   int hold_left    = 0;
   logic hold_ask   = 1'b0;
   logic hold_done  = 1'b0;
   logic quiet      = 1'b0;

   logic [31:0] pool [8];
   logic [31:0] recent [16];

   deque_with_value_delete_and_max_top dut (.*);

   deque_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_value       (req_value),
      .req_position    (req_position),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_read_value  (rsp_read_value),
      .rsp_max_value   (rsp_max_value),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_is_full     (rsp_is_full),
      .rsp_found       (rsp_found),
      .fail_count      (fail_count),
      .pending         (pending),
      .checked         (checked),
      .drops           (drops),
      .delete_hits     (delete_hits)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // random idle, then hold the word until the DUT takes it
   task automatic offer_word(input deque_op_pkg::deque_op_type op, input logic [31:0] val,
                             input logic [3:0] pos);
      while (!quiet && $urandom_range(99) < 29) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_mode     <= op;
      req_value    <= val;
      req_position <= pos;
      do @(posedge clock); while (!req_ready);
      words_sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // receiver: random back-pressure, one long hold-off, and a stretch always ready
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_ask && !hold_done) begin
         rsp_ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (quiet) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= 29);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
         $display("%0t: timeout, no handshake for %0d cycles, %0d responses outstanding",
                  $time, STALL_LIMIT, pending);
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      int                         n, r, ring;
      int                         push_cut, del_cut, read_cut, clear_cut;
      deque_op_pkg::deque_op_type op;
      logic [31:0]                val;

      pool[0] = 32'h0000_0000;
      pool[1] = 32'h0000_0001;
      pool[2] = 32'hFFFF_FFFF;
      pool[3] = 32'h0000_0007;
      pool[4] = 32'h7FFF_FFFF;
      pool[5] = 32'h8000_0000;
      pool[6] = $urandom();
      pool[7] = $urandom();
      for (int i = 0; i < 16; i++) recent[i] = pool[i % 8];
      ring = 0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: empty-queue ops, extremes, duplicates, misses, unused modes
      offer_word(deque_op_pkg::OP_READ,       32'h0000_0000, 4'd0);
      offer_word(deque_op_pkg::OP_DELETE,     32'h0000_0000, 4'd0);
      offer_word(deque_op_pkg::OP_PUSH_FRONT, 32'h7FFF_FFFF, 4'd0);
      offer_word(deque_op_pkg::OP_PUSH_BACK,  32'h8000_0000, 4'd0);
      offer_word(deque_op_pkg::OP_PUSH_FRONT, 32'hFFFF_FFFF, 4'd0);
      offer_word(deque_op_pkg::OP_PUSH_BACK,  32'h0000_0005, 4'd0);
      offer_word(deque_op_pkg::OP_PUSH_BACK,  32'h0000_0005, 4'd0);
      offer_word(deque_op_pkg::OP_READ,       32'h0000_0000, 4'd0);
      offer_word(deque_op_pkg::OP_READ,       32'hFFFF_FFFF, 4'd4);
      offer_word(deque_op_pkg::OP_READ,       32'h0000_0000, 4'd15);
      offer_word(deque_op_pkg::OP_DELETE,     32'h0000_0005, 4'd0);
      offer_word(deque_op_pkg::OP_DELETE,     32'h0000_004D, 4'd0);
      offer_word(deque_op_pkg::OP_UNUSED5,    32'h0000_0000, 4'd0);
      offer_word(deque_op_pkg::OP_UNUSED6,    32'h7FFF_FFFF, 4'd7);
      offer_word(deque_op_pkg::OP_UNUSED7,    32'hFFFF_FFFF, 4'd15);
      offer_word(deque_op_pkg::OP_DELETE,     32'h7FFF_FFFF, 4'd0);
      offer_word(deque_op_pkg::OP_CLEAR,      32'hFFFF_FFFF, 4'd15);
      offer_word(deque_op_pkg::OP_READ,       32'h0000_0000, 4'd0);
      drain_results();

      // random: alternate fill-heavy and drain-heavy windows of 48 words
      for (n = 0; n < RANDOM_WORDS; n++) begin
         if (n == 300) hold_ask <= 1'b1;
         if (n == 500) quiet <= 1'b1;
         if (n == 700) quiet <= 1'b0;
         if (n == 900) drain_results();
         if (((n / 48) % 2) == 0) begin
            push_cut = 70; del_cut = 78; read_cut = 96; clear_cut = 97;
         end else begin
            push_cut = 35; del_cut = 65; read_cut = 88; clear_cut = 93;
         end
         r = $urandom_range(99);
         if (r < push_cut) begin
            op = (r % 2) ? deque_op_pkg::OP_PUSH_BACK : deque_op_pkg::OP_PUSH_FRONT;
         end
         else if (r < del_cut) op = deque_op_pkg::OP_DELETE;
         else if (r < read_cut) op = deque_op_pkg::OP_READ;
         else if (r < clear_cut) op = deque_op_pkg::OP_CLEAR;
         else begin
            case ($urandom_range(2))
               0: op = deque_op_pkg::OP_UNUSED5;
               1: op = deque_op_pkg::OP_UNUSED6;
               default: op = deque_op_pkg::OP_UNUSED7;
            endcase
         end
         // values mostly from a small pool or recent pushes so deletes hit and repeat
         r = $urandom_range(9);
         if (r < 4) val = pool[$urandom_range(7)];
         else if (r < 7) val = recent[$urandom_range(15)];
         else val = $urandom();
         if (op == deque_op_pkg::OP_PUSH_FRONT || op == deque_op_pkg::OP_PUSH_BACK) begin
            recent[ring] = val;
            ring = (ring + 1) % 16;
         end
         offer_word(op, val, 4'($urandom_range(15)));
      end

      drain_results();
      repeat (40) @(posedge clock);

      $display("Covered %0d words, %0d responses checked: %0d pushes dropped at full,",
               words_sent, checked, drops);
      $display("%0d deletes that removed entries, %0d mismatches", delete_hits, fail_count);
      if (fail_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule

>>> deque_with_value_delete_and_max_top.f
+incdir+sv
sv/dqvdm_pkg.sv
sv/dqvdm_cell.sv
sv/deque_with_value_delete_and_max_top.sv
dv/deque_checker.sv
dv/tb_top.sv
